/* rtl/dctf_pkg.sv */
`timescale 1ns / 1ps

package dctf_pkg;

    localparam int FRAME_LEN_DEF = 64;
    localparam int MAX_COEFFS    = 64;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int ACC_W    = 48;
    localparam int COEFF_W  = 32;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;

    localparam logic [1:0] TYPE_I   = 2'd0;
    localparam logic [1:0] TYPE_II  = 2'd1;
    localparam logic [1:0] TYPE_OCT = 2'd2;

    localparam logic [1:0] REG_DCT_TYPE  = 2'd0;
    localparam logic [1:0] REG_SCALE     = 2'd1;
    localparam logic [1:0] REG_OUT_COUNT = 2'd2;

    localparam logic [1:0]       DCT_TYPE_RST  = TYPE_II;
    localparam logic             SCALE_RST     = 1'b1;
    localparam logic [CNT_W-1:0] OUT_COUNT_RST = 7'd64;

    localparam int    CORDIC_STEPS = 30;
    localparam longint CORDIC_GAIN = 64'sd652032874;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DUMP
    } state_t;

    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         k;
        logic signed [COEF_W-1:0] coef;
    } coef_req_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] n;
    } dump_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } acc_stat_t;

    // arctangent table, 2^32 = one full turn
    function automatic longint atan_turn(input int k);
        longint r;
        case (k)
            0:       r = 536870912;
            1:       r = 316933406;
            2:       r = 167458907;
            3:       r = 85004756;
            4:       r = 42667331;
            5:       r = 21354465;
            6:       r = 10679838;
            7:       r = 5340245;
            8:       r = 2670163;
            9:       r = 1335087;
            10:      r = 667544;
            11:      r = 333772;
            12:      r = 166886;
            13:      r = 83443;
            14:      r = 41722;
            15:      r = 20861;
            16:      r = 10430;
            17:      r = 5215;
            18:      r = 2608;
            19:      r = 1304;
            20:      r = 652;
            21:      r = 326;
            22:      r = 163;
            23:      r = 81;
            24:      r = 41;
            25:      r = 20;
            26:      r = 10;
            27:      r = 5;
            28:      r = 3;
            29:      r = 1;
            default: r = 0;
        endcase
        return r;
    endfunction

    // Q30 cosine of a 32-bit phase
    function automatic logic signed [31:0] cos_q30(input logic [31:0] phase);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        logic signed [31:0] r;
        z = longint'({34'd0, phase[29:0]});
        x = CORDIC_GAIN;
        y = 0;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_turn(k);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_turn(k);
            end
        end
        case (phase[31:30])
            2'd0:    r = 32'(x);
            2'd1:    r = 32'(-y);
            2'd2:    r = 32'(-x);
            default: r = 32'(y);
        endcase
        return r;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_m;
        v     = val;
        res   = 64'd0;
        bit_m = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (v >= res + bit_m) begin
                v   = v - (res + bit_m);
                res = (res >> 1) + bit_m;
            end else begin
                res = res >> 1;
            end
            bit_m = bit_m >> 2;
        end
        return res;
    endfunction

endpackage

/* rtl/dctf_coef_gen.sv */
`timescale 1ns / 1ps

module dctf_coef_gen #(
    parameter int FRAME_LEN = dctf_pkg::FRAME_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [$clog2(FRAME_LEN)-1:0]   idx,
    input  logic [1:0]                     dct_type,
    input  logic                           scale,
    output dctf_pkg::coef_req_t            creq,
    output logic                           busy
);

    localparam int NACC  = (FRAME_LEN < dctf_pkg::MAX_COEFFS) ? FRAME_LEN : dctf_pkg::MAX_COEFFS;
    localparam int KW    = $clog2(NACC);
    localparam int IW    = $clog2(FRAME_LEN);
    localparam int TURN1 = 2 * (FRAME_LEN - 1);
    localparam int TURN2 = 4 * FRAME_LEN;
    localparam int MW    = $clog2(TURN2);
    localparam logic [KW-1:0] KMAX = KW'(NACC - 1);

    function automatic logic [TURN1*32-1:0] build_cos1();
        logic [TURN1*32-1:0] tab;
        logic [63:0]         ph;
        tab = '0;
        for (int m = 0; m < TURN1; m++) begin
            ph = (64'(m) << 32) / TURN1;
            tab[32*m +: 32] = dctf_pkg::cos_q30(ph[31:0]);
        end
        return tab;
    endfunction

    function automatic logic [TURN2*32-1:0] build_cos2();
        logic [TURN2*32-1:0] tab;
        logic [63:0]         ph;
        tab = '0;
        for (int m = 0; m < TURN2; m++) begin
            ph = (64'(m) << 32) / TURN2;
            tab[32*m +: 32] = dctf_pkg::cos_q30(ph[31:0]);
        end
        return tab;
    endfunction

    localparam logic [TURN1*32-1:0] COS1_TAB = build_cos1();
    localparam logic [TURN2*32-1:0] COS2_TAB = build_cos2();

    localparam logic [30:0] NORM_ONE   = 31'(dctf_pkg::isqrt64(64'd1 << 60));
    localparam logic [30:0] NORM_HALF  = 31'(dctf_pkg::isqrt64(64'd1 << 59));
    localparam logic [30:0] NORM_I_S   =
        31'(dctf_pkg::isqrt64((64'd1 << 61) / 64'(FRAME_LEN - 1)));
    localparam logic [30:0] NORM_II_S0 =
        31'(dctf_pkg::isqrt64((64'd1 << 60) / 64'(FRAME_LEN)));
    localparam logic [30:0] NORM_II_S  =
        31'(dctf_pkg::isqrt64((64'd1 << 61) / 64'(FRAME_LEN)));

    logic              sweep_reg, sweep_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [MW-1:0]     m_reg, m_next;
    logic [MW-1:0]     step_reg;
    logic              endp_reg;

    logic              v1_reg, v2_reg, v3_reg;
    logic [KW-1:0]     k1_reg, k2_reg, k3_reg;
    logic signed [31:0] cos1_reg;
    logic [30:0]       norm1_reg;
    logic              sh1_reg, sh2_reg;
    logic signed [63:0] prod2_reg;
    logic signed [dctf_pkg::COEF_W-1:0] coef3_reg;

    logic              type1;
    logic              oct;
    logic signed [31:0] cos_sel;
    logic [30:0]       norm_sel;
    logic [MW:0]       msum;
    logic [MW:0]       turn;
    logic [MW:0]       m_wrap;
    logic              neg;
    logic [63:0]       mag;
    logic [63:0]       rnd;
    logic signed [dctf_pkg::COEF_W-1:0] coef_rnd;

    always_comb
    begin
        type1 = (dct_type == dctf_pkg::TYPE_I);
        oct   = (dct_type == dctf_pkg::TYPE_OCT);

        cos_sel = type1 ? COS1_TAB[32*m_reg +: 32] : COS2_TAB[32*m_reg +: 32];

        if (type1) begin
            norm_sel = scale ? NORM_I_S : NORM_ONE;
        end else if (k_reg == '0) begin
            norm_sel = scale ? NORM_II_S0 : (oct ? NORM_HALF : NORM_ONE);
        end else begin
            norm_sel = scale ? NORM_II_S : NORM_ONE;
        end

        msum   = {1'b0, m_reg} + {1'b0, step_reg};
        turn   = type1 ? (MW+1)'(TURN1) : (MW+1)'(TURN2);
        m_wrap = (msum >= turn) ? (msum - turn) : msum;

        sweep_next = sweep_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        if (start) begin
            sweep_next = 1'b1;
            k_next     = '0;
            m_next     = '0;
        end else if (sweep_reg) begin
            k_next = k_reg + KW'(1);
            m_next = m_wrap[MW-1:0];
            if (k_reg == KMAX) begin
                sweep_next = 1'b0;
            end
        end

        neg = prod2_reg[63];
        mag = neg ? 64'(-prod2_reg) : 64'(prod2_reg);
        rnd = sh2_reg ? ((mag + (64'd1 << 44)) >> 45) : ((mag + (64'd1 << 43)) >> 44);
        coef_rnd = neg ? -$signed({1'b0, rnd[16:0]}) : $signed({1'b0, rnd[16:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sweep_reg <= 1'b0;
            k_reg     <= '0;
            m_reg     <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end else begin
            sweep_reg <= sweep_next;
            k_reg     <= k_next;
            m_reg     <= m_next;
            v1_reg    <= sweep_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            step_reg <= type1 ? MW'(idx) : MW'({idx, 1'b1});
            endp_reg <= type1 && ((idx == '0) || (idx == IW'(FRAME_LEN - 1)));
        end
        k1_reg    <= k_reg;
        cos1_reg  <= cos_sel;
        norm1_reg <= norm_sel;
        sh1_reg   <= endp_reg;
        k2_reg    <= k1_reg;
        prod2_reg <= cos1_reg * $signed({1'b0, norm1_reg});
        sh2_reg   <= sh1_reg;
        k3_reg    <= k2_reg;
        coef3_reg <= coef_rnd;
    end

    assign creq.valid = v3_reg;
    assign creq.k     = dctf_pkg::IDX_W'(k3_reg);
    assign creq.coef  = coef3_reg;
    assign busy       = sweep_reg | v1_reg | v2_reg | v3_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("sweep started while coefficient pipeline busy");

endmodule

/* rtl/dctf_acc_core.sv */
`timescale 1ns / 1ps

module dctf_acc_core #(
    parameter int FRAME_LEN = dctf_pkg::FRAME_LEN_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dctf_pkg::coef_req_t                   creq,
    input  logic signed [dctf_pkg::SAMPLE_W-1:0]  sample,
    input  dctf_pkg::dump_ctl_t                   dump,
    output dctf_pkg::acc_stat_t                   stat,
    output logic signed [dctf_pkg::COEFF_W-1:0]   coeff,
    output logic [dctf_pkg::IDX_W-1:0]            coeff_index,
    output logic                                  last,
    output logic                                  out_valid,
    input  logic                                  out_stall
);

    localparam int NACC  = (FRAME_LEN < dctf_pkg::MAX_COEFFS) ? FRAME_LEN : dctf_pkg::MAX_COEFFS;
    localparam int KW    = $clog2(NACC);
    localparam int ACC_W = dctf_pkg::ACC_W;
    localparam int PW    = dctf_pkg::SAMPLE_W + dctf_pkg::COEF_W;
    localparam int CNT_W = dctf_pkg::CNT_W;

    logic signed [ACC_W-1:0] acc_mem [NACC];

    logic [NACC-1:0]         valid_reg, valid_next;
    logic signed [ACC_W-1:0] rd_data_reg;
    logic                    rd_vld_reg;
    logic signed [PW-1:0]    mprod_reg;
    logic [KW-1:0]           wk_reg;
    logic                    wv_reg;

    logic                    dump_active_reg, dump_active_next;
    logic [KW-1:0]           dump_k_reg, dump_k_next;
    logic [CNT_W-1:0]        dump_n_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [KW-1:0]           out_idx_reg;
    logic                    out_last_reg;

    logic                    dump_issue;
    logic                    dump_last;
    logic                    out_take;
    logic                    rd_en;
    logic [KW-1:0]           rd_addr;
    logic signed [ACC_W-1:0] acc_cur;
    logic signed [ACC_W-1:0] wsum;
    logic signed [ACC_W:0]   rsum;
    logic signed [ACC_W-8:0] rsh;
    logic [ACC_W-8:31]       rhi;

    always_comb
    begin
        dump_issue = dump_active_reg && (!out_valid_reg || !out_stall);
        dump_last  = (CNT_W'(dump_k_reg) + CNT_W'(1)) == dump_n_reg;
        out_take   = out_valid_reg && !out_stall;
        rd_en      = creq.valid || dump_issue;
        rd_addr    = creq.valid ? creq.k[KW-1:0] : dump_k_reg;
        acc_cur    = rd_vld_reg ? rd_data_reg : '0;
        wsum       = acc_cur + ACC_W'(mprod_reg);

        valid_next = valid_reg;
        if (wv_reg) begin
            valid_next[wk_reg] = 1'b1;
        end
        if (out_take && out_last_reg) begin
            valid_next = '0;
        end

        dump_active_next = dump_active_reg;
        dump_k_next      = dump_k_reg;
        if (dump.start) begin
            dump_active_next = 1'b1;
            dump_k_next      = '0;
        end else if (dump_issue) begin
            dump_k_next = dump_k_reg + KW'(1);
            if (dump_last) begin
                dump_active_next = 1'b0;
            end
        end

        out_valid_next = out_valid_reg;
        if (dump_issue) begin
            out_valid_next = 1'b1;
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end

        // round, then clip to 32 bits
        rsum = (ACC_W+1)'(acc_cur) + (ACC_W+1)'(128);
        rsh  = rsum[ACC_W:8];
        rhi  = rsh[ACC_W-8:31];
        if ((rhi == '0) || (rhi == '1)) begin
            coeff = rsh[31:0];
        end else if (rsh[ACC_W-8]) begin
            coeff = 32'sh8000_0000;
        end else begin
            coeff = 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg       <= '0;
            wv_reg          <= 1'b0;
            dump_active_reg <= 1'b0;
            dump_k_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            valid_reg       <= valid_next;
            wv_reg          <= creq.valid;
            dump_active_reg <= dump_active_next;
            dump_k_reg      <= dump_k_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wv_reg) begin
            acc_mem[wk_reg] <= wsum;
        end
        if (rd_en) begin
            rd_data_reg <= acc_mem[rd_addr];
            rd_vld_reg  <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (creq.valid) begin
            mprod_reg <= sample * creq.coef;
            wk_reg    <= creq.k[KW-1:0];
        end
        if (dump.start) begin
            dump_n_reg <= dump.n;
        end
        if (dump_issue) begin
            out_idx_reg  <= dump_k_reg;
            out_last_reg <= dump_last;
        end
    end

    assign coeff_index = dctf_pkg::IDX_W'(out_idx_reg);
    assign last        = out_last_reg;
    assign out_valid   = out_valid_reg;
    assign stat.busy   = wv_reg;
    assign stat.done   = out_take && out_last_reg;

    a_no_mac_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        !(wv_reg && dump_active_reg))
        else $error("accumulator write during readout");

endmodule

/* rtl/dct_frame_transform_top.sv */
`timescale 1ns / 1ps

// Sample: accepted in idle, then NACC = min(64, FRAME_LEN) multiply-accumulates, one per
// cycle through the separate read and write ports of the accumulator memory, then a
// pipeline drain before the next sample is accepted.
// Frame end: first coefficient valid once the closing sample's accumulates have drained
// (readout starts directly when that sample lies past FRAME_LEN), then one per cycle while out_stall is low.
// Reset: control idles, all accumulators read as zero, registers take reset values.

module dct_frame_transform_top #(
    parameter int FRAME_LEN = dctf_pkg::FRAME_LEN_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [dctf_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 frame_end,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [dctf_pkg::COEFF_W-1:0]  coeff,
    output logic [dctf_pkg::IDX_W-1:0]           coeff_index,
    output logic                                 last
);

    localparam int NACC  = (FRAME_LEN < dctf_pkg::MAX_COEFFS) ? FRAME_LEN : dctf_pkg::MAX_COEFFS;
    localparam int CW    = $clog2(FRAME_LEN + 1);
    localparam int IW    = $clog2(FRAME_LEN);
    localparam int CNT_W = dctf_pkg::CNT_W;

    dctf_pkg::state_t     state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic signed [dctf_pkg::SAMPLE_W-1:0] sample_reg;
    logic                 fe_reg;

    logic [1:0]           dct_type_reg;
    logic                 scale_reg;
    logic [CNT_W-1:0]     out_count_reg;

    logic                 cfg_wr;
    logic                 in_take;
    logic                 coef_start;
    logic                 coef_busy;
    logic [CNT_W-1:0]     n_clamp;

    dctf_pkg::coef_req_t  creq;
    dctf_pkg::dump_ctl_t  dump;
    dctf_pkg::acc_stat_t  stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dct_type_reg  <= dctf_pkg::DCT_TYPE_RST;
            scale_reg     <= dctf_pkg::SCALE_RST;
            out_count_reg <= dctf_pkg::OUT_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                dctf_pkg::REG_DCT_TYPE:  dct_type_reg  <= pwdata[1:0];
                dctf_pkg::REG_SCALE:     scale_reg     <= pwdata[0];
                dctf_pkg::REG_OUT_COUNT: out_count_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            dctf_pkg::REG_DCT_TYPE:  prdata = 32'(dct_type_reg);
            dctf_pkg::REG_SCALE:     prdata = 32'(scale_reg);
            dctf_pkg::REG_OUT_COUNT: prdata = 32'(out_count_reg);
            default:                 prdata = '0;
        endcase
    end

    assign in_stall = (state_reg != dctf_pkg::ST_IDLE);
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (out_count_reg == '0) begin
            n_clamp = CNT_W'(1);
        end else if (out_count_reg > CNT_W'(NACC)) begin
            n_clamp = CNT_W'(NACC);
        end else begin
            n_clamp = out_count_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        coef_start = 1'b0;
        dump.start = 1'b0;
        dump.n     = n_clamp;
        unique case (state_reg)
            dctf_pkg::ST_IDLE:
            begin
                if (in_take) begin
                    if (count_reg < CW'(FRAME_LEN)) begin
                        coef_start = 1'b1;
                        count_next = count_reg + CW'(1);
                        state_next = dctf_pkg::ST_MAC;
                    end else if (frame_end) begin
                        dump.start = 1'b1;
                        state_next = dctf_pkg::ST_DUMP;
                    end
                end
            end
            dctf_pkg::ST_MAC:
            begin
                if (!coef_busy && !stat.busy) begin
                    if (fe_reg) begin
                        dump.start = 1'b1;
                        state_next = dctf_pkg::ST_DUMP;
                    end else begin
                        state_next = dctf_pkg::ST_IDLE;
                    end
                end
            end
            dctf_pkg::ST_DUMP:
            begin
                if (stat.done) begin
                    count_next = '0;
                    state_next = dctf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dctf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= dctf_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            sample_reg <= sample;
            fe_reg     <= frame_end;
        end
    end

    dctf_coef_gen #(
        .FRAME_LEN (FRAME_LEN)
    ) u_coef_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (coef_start),
        .idx      (count_reg[IW-1:0]),
        .dct_type (dct_type_reg),
        .scale    (scale_reg),
        .creq     (creq),
        .busy     (coef_busy)
    );

    dctf_acc_core #(
        .FRAME_LEN (FRAME_LEN)
    ) u_acc_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .creq        (creq),
        .sample      (sample_reg),
        .dump        (dump),
        .stat        (stat),
        .coeff       (coeff),
        .coeff_index (coeff_index),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

    a_coef_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        creq.valid |-> (state_reg == dctf_pkg::ST_MAC))
        else $error("coefficient outside accumulate phase");

    a_out_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == dctf_pkg::ST_DUMP))
        else $error("result request outside readout");

    a_done_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> (state_reg == dctf_pkg::ST_IDLE) && (count_reg == '0))
        else $error("frame not closed after last coefficient");

endmodule
